@@ rtl/xcr_pkg.sv @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Shared sizes, codes, types and the CRC-16 bit step for the receiver.
// ----------------------------------------------------------------------------
package xcr_pkg;

   // frame geometry
   localparam int DATA_BYTES = 128;
   localparam int NWORDS     = (DATA_BYTES + 7) / 8;
   localparam int WORD_AW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CNT_W      = $clog2(DATA_BYTES + 4);

   // request queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // port widths
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;
   localparam int RSP_PAD_W  = RSP_DATA_W - 74;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 1'd1;
   localparam logic [7:0]           LIMIT_RESET       = 8'd5;

   // request kind codes on the wire
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_TIMEOUT = 2'd1;
   localparam logic [1:0] KIND_START   = 2'd2;

   // protocol bytes
   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] B_CRC = 8'h43;
   localparam logic [7:0] SAT_MAX = 8'hFF;

   // status codes
   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_RECEIVING = 2'd1;
   localparam logic [1:0] ST_FINISHED  = 2'd2;
   localparam logic [1:0] ST_CANCELLED = 2'd3;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [2:0]  CRC_REST = 3'd7;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_TIMEOUT,
      CMD_START
   } cmd_kind_type;

   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        data_valid;
      logic [63:0] data_word;
      logic        last;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_FRAME,
      PH_DONE,
      PH_CANCEL
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CRC,
      BK_RDREQ,
      BK_RDOUT
   } back_state_type;

   // one shift of the CRC-16/XMODEM register
   function automatic logic [15:0] crc_step(input logic [15:0] crc);
      crc_step = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
   endfunction

   function automatic logic [1:0] status_of(input phase_type ph);
      case (ph)
         PH_HEADER, PH_FRAME: status_of = ST_RECEIVING;
         PH_DONE:             status_of = ST_FINISHED;
         PH_CANCEL:           status_of = ST_CANCELLED;
         default:             status_of = ST_IDLE;
      endcase
   endfunction

endpackage

@@ rtl/xmodem_crc_receiver_unit.sv @@
// Timing: a header or control request has its result registered as the back end
// takes it from the queue, when the result register is free; a data byte holds the
// back end for one CRC step per bit (bit-serial) before the next byte is taken.
// A good frame drains 16 data words from the frame buffer, each read in BK_RDREQ
// and sent in BK_RDOUT, the ACK riding on the last word; the RAM read is registered.
// Reset (synchronous, active high): idle, limits 5, expected block 1, queue empty.
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver top level
// Configuration registers, front end request queue and protocol back end.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [xcr_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] rx_byte
   input  logic [xcr_pkg::REQ_USER_W-1:0]  req_tuser,   // [1:0] kind
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [xcr_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] tx_byte, [71:8] data_word,
                                                        // [73:72] status, rest zero
   output logic [xcr_pkg::RSP_USER_W-1:0]  rsp_tuser,   // [0] tx_valid, [1] data_valid
   output logic                            rsp_tlast,
   // configuration port
   input  logic                            csr_we,
   input  logic [xcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [xcr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [7:0]       err_limit_ff;
   logic [7:0]       to_limit_ff;
   xcr_pkg::cmd_type cmd;
   logic             cmd_pop;
   xcr_pkg::rsp_type rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         err_limit_ff <= xcr_pkg::LIMIT_RESET;
         to_limit_ff  <= xcr_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            xcr_pkg::CSR_ERROR_LIMIT:   err_limit_ff <= csr_wdata;
            xcr_pkg::CSR_TIMEOUT_LIMIT: to_limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   xcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_kind   (req_tuser),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   xcr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .error_limit   (err_limit_ff),
      .timeout_limit (to_limit_ff),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp)
   );

   // pack the result fields
   assign rsp_tdata = {{xcr_pkg::RSP_PAD_W{1'b0}}, rsp.status, rsp.data_word, rsp.tx_byte};
   assign rsp_tuser = {rsp.data_valid, rsp.tx_valid};
   assign rsp_tlast = rsp.last;

`ifndef SYNTHESIS
   // every result that carries a control byte closes its request, and only those do
   a_last_is_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser[0]))
      else $error("tlast does not match tx_valid");

   // a data result carries no control byte but the closing ACK
   a_data_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1] && rsp_tuser[0]) |-> (rsp_tdata[7:0] == xcr_pkg::B_ACK))
      else $error("data result carries a control byte other than ACK");

   // the request queue is empty and ready right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request channel not ready after reset");
`endif

endmodule

@@ rtl/xcr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module xcr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/xcr_front.sv @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver front end
// Accepts requests, classifies the kind and queues commands for the back end.
// ----------------------------------------------------------------------------
module xcr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_byte,
   input  logic [1:0]            req_kind,
   output xcr_pkg::cmd_type      cmd,
   input  logic                  cmd_pop
);

   xcr_pkg::cmd_type          q_ff [xcr_pkg::QDEPTH];
   xcr_pkg::cmd_type          q_in;
   logic [xcr_pkg::QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [xcr_pkg::QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [xcr_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                      push;
   logic                      pop;

   assign req_tready = (count_ff != xcr_pkg::QCNT_W'(xcr_pkg::QDEPTH));

   // classify the request; unused kinds are dropped
   always_comb begin
      q_in       = '0;
      q_in.data  = req_byte;
      q_in.valid = 1'b1;
      push       = req_tvalid && req_tready;
      case (req_kind)
         xcr_pkg::KIND_BYTE:    q_in.kind = xcr_pkg::CMD_BYTE;
         xcr_pkg::KIND_TIMEOUT: q_in.kind = xcr_pkg::CMD_TIMEOUT;
         xcr_pkg::KIND_START:   q_in.kind = xcr_pkg::CMD_START;
         default: begin
            q_in.kind = xcr_pkg::CMD_BYTE;
            push      = 1'b0;
         end
      endcase
   end

   assign pop = cmd_pop && (count_ff != '0);

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   always_comb begin
      cmd       = q_ff[rd_ptr_ff];
      cmd.valid = (count_ff != '0);
   end

endmodule

@@ rtl/xcr_back.sv @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver back end
// Runs the protocol state, the bit-serial CRC, the frame buffer and the
// result register.
// ----------------------------------------------------------------------------
module xcr_back (
   input  logic              clock,
   input  logic              reset,
   input  xcr_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  logic [7:0]        error_limit,
   input  logic [7:0]        timeout_limit,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xcr_pkg::rsp_type  rsp
);

   localparam logic [xcr_pkg::CNT_W-1:0] CNT_DATA_END = xcr_pkg::CNT_W'(xcr_pkg::DATA_BYTES + 2);
   localparam logic [xcr_pkg::CNT_W-1:0] CNT_CRC_HI   = xcr_pkg::CNT_W'(xcr_pkg::DATA_BYTES + 2);
   localparam logic [xcr_pkg::CNT_W-1:0] CNT_SAT      = xcr_pkg::CNT_W'(xcr_pkg::DATA_BYTES + 3);
   localparam logic [xcr_pkg::CNT_W-1:0] CNT_BLK      = xcr_pkg::CNT_W'(0);
   localparam logic [xcr_pkg::CNT_W-1:0] CNT_CMP      = xcr_pkg::CNT_W'(1);
   localparam logic [xcr_pkg::CNT_W-1:0] CNT_DATA0    = xcr_pkg::CNT_W'(2);
   localparam logic [xcr_pkg::WORD_AW-1:0] LAST_WORD  = xcr_pkg::WORD_AW'(xcr_pkg::NWORDS - 1);

   xcr_pkg::back_state_type bst_ff, bst_in;
   xcr_pkg::phase_type      phase_ff, phase_in;
   logic [xcr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [7:0]                  exp_blk_ff, exp_blk_in;
   logic [7:0]                  err_cnt_ff, err_cnt_in;
   logic [7:0]                  to_cnt_ff, to_cnt_in;
   logic [7:0]                  blk_num_ff, blk_num_in;
   logic [7:0]                  blk_cmp_ff, blk_cmp_in;
   logic [15:0]                 crc_ff, crc_in;
   logic [7:0]                  crc_hi_ff, crc_hi_in;
   logic [63:0]                 word_ff, word_in;
   logic [2:0]                  bit_cnt_ff, bit_cnt_in;
   logic [xcr_pkg::WORD_AW-1:0] rd_idx_ff, rd_idx_in;
   logic                        out_valid_ff, out_valid_in;
   xcr_pkg::rsp_type            out_ff, out_in;

   logic                        out_free;
   logic                        ram_we;
   logic                        ram_re;
   logic [63:0]                 ram_rdata;
   logic [xcr_pkg::CNT_W-1:0]   data_idx;
   logic [xcr_pkg::WORD_AW-1:0] word_idx;
   logic [7:0]                  err_sat;
   logic                        fin_word;
   logic                        emit;
   logic [7:0]                  emit_byte;

   assign out_free = !out_valid_ff || rsp_ready;
   assign data_idx = cnt_ff - CNT_DATA0;
   assign word_idx = data_idx[3 +: xcr_pkg::WORD_AW];
   assign err_sat  = (err_cnt_ff != xcr_pkg::SAT_MAX) ? err_cnt_ff + 8'd1 : err_cnt_ff;
   assign fin_word = (rd_idx_ff == LAST_WORD);

   xcr_ram #(
      .WIDTH (64),
      .DEPTH (xcr_pkg::NWORDS),
      .AW    (xcr_pkg::WORD_AW)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (word_idx),
      .wdata (word_in),
      .re    (ram_re),
      .raddr (rd_idx_ff),
      .rdata (ram_rdata)
   );

   // protocol sequencer: next state and result
   always_comb begin
      bst_in     = bst_ff;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      exp_blk_in = exp_blk_ff;
      err_cnt_in = err_cnt_ff;
      to_cnt_in  = to_cnt_ff;
      blk_num_in = blk_num_ff;
      blk_cmp_in = blk_cmp_ff;
      crc_in     = crc_ff;
      crc_hi_in  = crc_hi_ff;
      word_in    = word_ff;
      bit_cnt_in = bit_cnt_ff;
      rd_idx_in  = rd_idx_ff;
      cmd_pop    = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      emit       = 1'b0;
      emit_byte  = xcr_pkg::B_NAK;
      out_in     = out_ff;

      case (bst_ff)
         xcr_pkg::BK_IDLE: begin
            if (cmd.valid && out_free) begin
               cmd_pop = 1'b1;
               if (cmd.kind == xcr_pkg::CMD_START) begin
                  err_cnt_in = '0;
                  to_cnt_in  = '0;
                  exp_blk_in = 8'd1;
                  cnt_in     = '0;
                  phase_in   = xcr_pkg::PH_HEADER;
                  emit       = 1'b1;
                  emit_byte  = xcr_pkg::B_CRC;
               end else if (phase_ff == xcr_pkg::PH_HEADER) begin
                  if (cmd.kind == xcr_pkg::CMD_BYTE && cmd.data == xcr_pkg::B_SOH) begin
                     phase_in = xcr_pkg::PH_FRAME;
                     cnt_in   = '0;
                     crc_in   = '0;
                  end else if (cmd.kind == xcr_pkg::CMD_BYTE &&
                               cmd.data == xcr_pkg::B_EOT) begin
                     phase_in  = xcr_pkg::PH_DONE;
                     emit      = 1'b1;
                     emit_byte = xcr_pkg::B_ACK;
                  end else begin
                     err_cnt_in = err_sat;
                     emit       = 1'b1;
                     if (err_sat > error_limit) begin
                        phase_in  = xcr_pkg::PH_CANCEL;
                        emit_byte = xcr_pkg::B_CAN;
                     end
                  end
               end else if (phase_ff == xcr_pkg::PH_FRAME) begin
                  if (cmd.kind == xcr_pkg::CMD_TIMEOUT) begin
                     emit = 1'b1;
                     if (to_cnt_ff > timeout_limit) begin
                        phase_in  = xcr_pkg::PH_CANCEL;
                        emit_byte = xcr_pkg::B_CAN;
                     end else begin
                        if (to_cnt_ff != xcr_pkg::SAT_MAX) begin
                           to_cnt_in = to_cnt_ff + 8'd1;
                        end
                        phase_in = xcr_pkg::PH_HEADER;
                        cnt_in   = '0;
                     end
                  end else begin
                     if (cnt_ff < CNT_SAT) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                     if (cnt_ff == CNT_BLK) begin
                        blk_num_in = cmd.data;
                     end else if (cnt_ff == CNT_CMP) begin
                        blk_cmp_in = cmd.data;
                     end else if (cnt_ff < CNT_DATA_END) begin
                        // pack the byte into its word lane and start the CRC
                        if (data_idx[2:0] == 3'd0) begin
                           word_in = {56'd0, cmd.data};
                        end else begin
                           word_in = word_ff | ({56'd0, cmd.data} << {data_idx[2:0], 3'b000});
                        end
                        ram_we     = 1'b1;
                        crc_in     = xcr_pkg::crc_step(crc_ff ^ {cmd.data, 8'h00});
                        bit_cnt_in = xcr_pkg::CRC_REST;
                        bst_in     = xcr_pkg::BK_CRC;
                     end else if (cnt_ff == CNT_CRC_HI) begin
                        crc_hi_in = cmd.data;
                     end else begin
                        // frame complete: check and answer
                        to_cnt_in = '0;
                        phase_in  = xcr_pkg::PH_HEADER;
                        cnt_in    = '0;
                        if (blk_num_ff == exp_blk_ff && blk_cmp_ff == ~blk_num_ff &&
                            {crc_hi_ff, cmd.data} == crc_ff) begin
                           exp_blk_in = exp_blk_ff + 8'd1;
                           rd_idx_in  = '0;
                           bst_in     = xcr_pkg::BK_RDREQ;
                        end else begin
                           emit = 1'b1;
                        end
                     end
                  end
               end
            end
         end

         xcr_pkg::BK_CRC: begin
            crc_in     = xcr_pkg::crc_step(crc_ff);
            bit_cnt_in = bit_cnt_ff - 3'd1;
            if (bit_cnt_ff == 3'd1) begin
               bst_in = xcr_pkg::BK_IDLE;
            end
         end

         xcr_pkg::BK_RDREQ: begin
            ram_re = 1'b1;
            bst_in = xcr_pkg::BK_RDOUT;
         end

         xcr_pkg::BK_RDOUT: begin
            if (out_free) begin
               out_in.tx_valid   = fin_word;
               out_in.tx_byte    = fin_word ? xcr_pkg::B_ACK : 8'd0;
               out_in.data_valid = 1'b1;
               out_in.data_word  = ram_rdata;
               out_in.last       = fin_word;
               out_in.status     = xcr_pkg::status_of(phase_ff);
               if (fin_word) begin
                  bst_in = xcr_pkg::BK_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
                  bst_in    = xcr_pkg::BK_RDREQ;
               end
            end
         end

         default: bst_in = xcr_pkg::BK_IDLE;
      endcase

      // single control byte result
      if (emit) begin
         out_in.tx_valid   = 1'b1;
         out_in.tx_byte    = emit_byte;
         out_in.data_valid = 1'b0;
         out_in.data_word  = '0;
         out_in.last       = 1'b1;
         out_in.status     = xcr_pkg::status_of(phase_in);
      end

      // result register valid
      if (emit || (bst_ff == xcr_pkg::BK_RDOUT && out_free)) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bst_ff       <= xcr_pkg::BK_IDLE;
         phase_ff     <= xcr_pkg::PH_IDLE;
         cnt_ff       <= '0;
         exp_blk_ff   <= 8'd1;
         err_cnt_ff   <= '0;
         to_cnt_ff    <= '0;
         blk_num_ff   <= '0;
         blk_cmp_ff   <= '0;
         crc_ff       <= '0;
         crc_hi_ff    <= '0;
         bit_cnt_ff   <= '0;
         rd_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         bst_ff       <= bst_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         exp_blk_ff   <= exp_blk_in;
         err_cnt_ff   <= err_cnt_in;
         to_cnt_ff    <= to_cnt_in;
         blk_num_ff   <= blk_num_in;
         blk_cmp_ff   <= blk_cmp_in;
         crc_ff       <= crc_in;
         crc_hi_ff    <= crc_hi_in;
         bit_cnt_ff   <= bit_cnt_in;
         rd_idx_ff    <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule
